@@ src/tlpd_pkg.sv @@
package tlpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned Q_DEPTH  = 8;
  localparam int unsigned Q_AW     = 3;
  localparam int unsigned Q_CW     = 4;

  localparam logic [BYTE_W-1:0] PRIMARY_TAG_RST   = 8'd247;
  localparam logic [BYTE_W-1:0] SECONDARY_TAG_RST = 8'd248;

  localparam int unsigned MIN_LENGTH   = 4;
  localparam int unsigned HDR_LAST_POS = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIMARY_TAG   = 1'd0,
    REG_SECONDARY_TAG = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_HDR  = 2'd0,
    OP_DATA = 2'd1,
    OP_ERR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_TAG = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  // one queue entry: a header burst of four beats, one payload beat or an error beat
  typedef struct packed {
    op_t                        op;
    logic [3:0][BYTE_W-1:0]     data;
    logic                       kind;
    logic                       last;
    status_t                    status;
    logic [COUNT_W-1:0]         count;
  } entry_t;

endpackage

@@ src/tlpd_front.sv @@
module tlpd_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_rx_byte,
  output logic                   in_ready,
  input  logic [7:0]             primary_tag,
  input  logic [7:0]             secondary_tag,
  input  logic                   q_full,
  output logic                   q_push,
  output tlpd_pkg::entry_t       q_entry
);
  import tlpd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] POS_HDR = LENGTH_BITS'(HDR_LAST_POS);
  localparam logic [LENGTH_BITS-1:0] LEN_MIN = LENGTH_BITS'(MIN_LENGTH);
  localparam logic [LENGTH_BITS-1:0] POS_ONE = LENGTH_BITS'(1);

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0]      held_r [3];
  logic                   held_we;
  logic                   kind_r, kind_nxt;
  logic                   dead_r, dead_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;

  logic                   acc;
  logic [15:0]            len_raw;
  logic [LENGTH_BITS-1:0] len_v;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic                   hit_p, hit_s;
  logic                   last;

  assign in_ready = dead_r || !q_full;
  assign acc      = in_valid && in_ready;
  assign len_raw  = {in_rx_byte, held_r[2]};
  assign len_v    = len_raw[LENGTH_BITS-1:0];
  assign pos_inc  = pos_r + POS_ONE;
  assign hit_p    = (held_r[0] == primary_tag);
  assign hit_s    = (held_r[0] == secondary_tag);

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    kind_nxt = kind_r;
    dead_nxt = dead_r;
    cnt_nxt  = cnt_r;
    held_we  = 1'b0;
    q_push   = 1'b0;
    q_entry  = '0;
    last     = 1'b0;
    if (acc && !dead_r) begin
      priority if (pos_r < POS_HDR) begin
        held_we = 1'b1;
        pos_nxt = pos_inc;
      end else if (pos_r == POS_HDR) begin
        q_push = 1'b1;
        priority if (!hit_p && !hit_s) begin
          dead_nxt       = 1'b1;
          q_entry.op     = OP_ERR;
          q_entry.status = ST_BAD_TAG;
        end else if (len_v < LEN_MIN) begin
          dead_nxt       = 1'b1;
          q_entry.op     = OP_ERR;
          q_entry.status = ST_SHORT;
        end else begin
          kind_nxt = !hit_p;
          len_nxt  = len_v;
          last     = (len_v == LEN_MIN);
          if (last) begin
            pos_nxt = '0;
            if (hit_p) begin
              cnt_nxt = cnt_r + COUNT_W'(1);
            end
          end else begin
            pos_nxt = pos_inc;
          end
          q_entry.op     = OP_HDR;
          q_entry.data   = {in_rx_byte, held_r[2], held_r[1], held_r[0]};
          q_entry.kind   = !hit_p;
          q_entry.last   = last;
          q_entry.status = ST_OK;
        end
        q_entry.count = cnt_nxt;
      end else begin
        q_push = 1'b1;
        last   = (pos_inc >= len_r);
        if (last) begin
          pos_nxt = '0;
          if (!kind_r) begin
            cnt_nxt = cnt_r + COUNT_W'(1);
          end
        end else begin
          pos_nxt = pos_inc;
        end
        q_entry.op      = OP_DATA;
        q_entry.data[0] = in_rx_byte;
        q_entry.kind    = kind_r;
        q_entry.last    = last;
        q_entry.status  = ST_OK;
        q_entry.count   = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      kind_r <= 1'b0;
      dead_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      kind_r <= kind_nxt;
      dead_r <= dead_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_r[pos_r[1:0]] <= in_rx_byte;
    end
  end

endmodule

@@ src/tlpd_queue.sv @@
module tlpd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlpd_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tlpd_pkg::entry_t  head_entry
);
  import tlpd_pkg::*;

  entry_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt;
  logic [Q_AW-1:0]   rd_r, rd_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == Q_CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + Q_AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + Q_AW'(1) : rd_r;
    cnt_nxt = cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

@@ src/tlpd_back.sv @@
module tlpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tlpd_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_tag_kind,
  output logic              out_first_of_packet,
  output logic              out_last_of_packet,
  output logic [1:0]        out_status,
  output logic [31:0]       out_primary_count
);
  import tlpd_pkg::*;

  entry_t      cur_r;
  logic        vld_r, vld_nxt;
  logic [1:0]  beat_r, beat_nxt;
  logic        last_beat;
  logic        load;

  assign last_beat = (cur_r.op == OP_HDR) ? (beat_r == 2'd3) : 1'b1;
  assign load      = q_valid && (!vld_r || (out_ready && last_beat));
  assign q_pop     = load;

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (load) begin
      vld_nxt  = 1'b1;
      beat_nxt = '0;
    end else if (vld_r && out_ready) begin
      if (last_beat) begin
        vld_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_entry;
    end
  end

  assign out_valid           = vld_r;
  assign out_byte            = cur_r.data[beat_r];
  assign out_tag_kind        = cur_r.kind;
  assign out_first_of_packet = (cur_r.op == OP_HDR) && (beat_r == 2'd0);
  assign out_last_of_packet  = last_beat && cur_r.last;
  assign out_status          = cur_r.status;
  assign out_primary_count   = cur_r.count;

endmodule

@@ src/tag_length_packet_deframer_core.sv @@
// Path: a beat that yields results is written into an eight-entry queue, then into
// the output register. Throughput: one input byte per cycle while the queue is not
// full; one result beat per cycle, four for a header burst, while out_ready is high.
// Reset: synchronous, active low; clears position, length, error flag, counter and
// queue, and loads the tags with 247 and 248.
module tag_length_packet_deframer_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_tag_kind,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic [1:0]  out_status,
  output logic [31:0] out_primary_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import tlpd_pkg::*;

  logic [BYTE_W-1:0] ptag_r, stag_r;
  logic              q_full, q_push, q_pop, q_valid;
  entry_t            push_entry, head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r <= PRIMARY_TAG_RST;
      stag_r <= SECONDARY_TAG_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRIMARY_TAG:   ptag_r <= cfg_wdata;
        REG_SECONDARY_TAG: stag_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tlpd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_rx_byte    (in_rx_byte),
    .in_ready      (in_ready),
    .primary_tag   (ptag_r),
    .secondary_tag (stag_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  tlpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  tlpd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_entry             (head_entry),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_tag_kind        (out_tag_kind),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_status          (out_status),
    .out_primary_count   (out_primary_count)
  );

endmodule
